### rtl/ray_triangle_hit_test_assert.svh
// Assertion macros for the ray/triangle hit test
`ifndef RAY_TRIANGLE_HIT_TEST_ASSERT_SVH
`define RAY_TRIANGLE_HIT_TEST_ASSERT_SVH

// Same-cycle implication, off during reset
`define RTH_CHECK(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication a fixed number of cycles later, off during reset
`define RTH_CHECK_DLY(label, ante, dly, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> ##dly (cons)) else $error(msg);

`endif

### rtl/rth_pkg.sv
// Shared types, widths and constants for the ray/triangle hit test
package rth_pkg;

    localparam int CW     = 16;            // coordinate width, Q7.8
    localparam int CF     = 8;             // coordinate fraction bits
    localparam int NW     = 16;            // normal component width, Q1.14
    localparam int NF     = 14;            // normal fraction bits
    localparam int DEN_W  = CW + NW + 2;   // dot(dir, normal)
    localparam int NUM_W  = CW + NW + 3;   // plane numerator
    localparam int SPL    = 18;            // split of numerator for partial products
    localparam int DIVD_W = CW + NUM_W;    // |dir * num|
    localparam int QW     = CW + 1;        // quotient bits kept before saturation
    localparam int RW     = CW + 1;        // vertex differences
    localparam int CRS_W  = 2 * RW + 1;    // cross product component
    localparam int EDP_W  = CRS_W + NW;    // cross component times normal
    localparam int EDS_W  = EDP_W + 2;     // edge value
    localparam int REG_W  = 48;
    localparam int DATA_W = 64;
    localparam int ADDR_W = 5;
    localparam int LAT    = 4 + (QW + 1) + 5;

    localparam logic [DEN_W-1:0] EPS_DEN = DEN_W'((64'd1 << (CF + NF)) / 64'd10000);

    typedef enum logic [1:0] {
        REG_VA  = 2'd0,
        REG_VB  = 2'd1,
        REG_VC  = 2'd2,
        REG_NRM = 2'd3
    } t_reg_idx;

    typedef logic signed [CW-1:0] t_coord;
    typedef logic signed [NW-1:0] t_nrm;

    // triangle as set up by software
    typedef struct {
        t_coord va [3];
        t_coord vb [3];
        t_coord vc [3];
        t_nrm   n  [3];
    } t_tri;

    // plane stage to divider
    typedef struct {
        logic              ok;
        t_coord            o    [3];
        logic              dneg [3];
        logic [DIVD_W-1:0] a    [3];
        logic [DEN_W-1:0]  b;
    } t_pl_out;

    // divider to edge stage
    typedef struct {
        logic          ok;
        t_coord        o    [3];
        logic          dneg [3];
        logic          sat  [3];
        logic [QW-1:0] q    [3];
    } t_dv_out;

    function automatic t_coord get_coord(input logic [REG_W-1:0] r, input int i);
        return r[i*CW +: CW];
    endfunction

endpackage

### rtl/rth_plane.sv
// Plane stages: dot products, acceptance test and dividend magnitudes
module rth_plane (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  rth_pkg::t_coord i_o [3],
    input  rth_pkg::t_coord i_d [3],
    input  logic            i_back,
    input  rth_pkg::t_tri   i_tri,
    output logic            o_valid,
    output rth_pkg::t_pl_out o_pl
);
    import rth_pkg::*;

    logic                     r1_v, r2_v, r3_v;
    logic signed [CW+NW-1:0]  r1_dn [3];
    logic signed [CW+NW-1:0]  r1_na [3];
    logic signed [CW+NW-1:0]  r1_on [3];
    t_coord                   r1_o  [3];
    t_coord                   r1_d  [3];
    logic                     r1_back;

    logic signed [DEN_W-1:0]  n_den;
    logic signed [NUM_W-1:0]  n_num;
    logic [DEN_W-1:0]         n_absden;
    logic [NUM_W-1:0]         n_absnum;
    logic                     n_ok;

    logic                     r2_ok, r3_ok;
    logic [DEN_W-1:0]         r2_absden, r3_absden;
    logic [NUM_W-1:0]         r2_absnum;
    logic [CW-1:0]            r2_absd [3];
    t_coord                   r2_o [3], r3_o [3];
    logic                     r2_dneg [3], r3_dneg [3];
    logic [CW+SPL-1:0]        r3_pl [3];
    logic [CW+NUM_W-SPL-1:0]  r3_ph [3];

    // S1: all nine products
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else begin
            r1_v <= i_valid;
        end
        for (int k = 0; k < 3; k++) begin
            r1_dn[k] <= i_d[k] * i_tri.n[k];
            r1_na[k] <= i_tri.n[k] * i_tri.va[k];
            r1_on[k] <= i_o[k] * i_tri.n[k];
            r1_o[k]  <= i_o[k];
            r1_d[k]  <= i_d[k];
        end
        r1_back <= i_back;
    end

    // S2: sums and accept decision
    always_comb begin
        n_den = DEN_W'(r1_dn[0]) + DEN_W'(r1_dn[1]) + DEN_W'(r1_dn[2]);
        n_num = NUM_W'(r1_na[0]) + NUM_W'(r1_na[1]) + NUM_W'(r1_na[2])
              - NUM_W'(r1_on[0]) - NUM_W'(r1_on[1]) - NUM_W'(r1_on[2]);
        n_absden = n_den[DEN_W-1] ? DEN_W'(-n_den) : DEN_W'(n_den);
        n_absnum = n_num[NUM_W-1] ? NUM_W'(-n_num) : NUM_W'(n_num);
        n_ok = (r1_back ? (n_absden > EPS_DEN) : n_den[DEN_W-1])
             && (n_num != '0) && (n_num[NUM_W-1] == n_den[DEN_W-1]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else begin
            r2_v <= r1_v;
        end
        r2_ok     <= n_ok;
        r2_absden <= n_absden;
        r2_absnum <= n_absnum;
        for (int k = 0; k < 3; k++) begin
            r2_absd[k] <= r1_d[k][CW-1] ? CW'(-r1_d[k]) : CW'(r1_d[k]);
            r2_dneg[k] <= r1_d[k][CW-1];
            r2_o[k]    <= r1_o[k];
        end
    end

    // S3: |dir| * |num| as two partial products
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else begin
            r3_v <= r2_v;
        end
        r3_ok     <= r2_ok;
        r3_absden <= r2_absden;
        for (int k = 0; k < 3; k++) begin
            r3_pl[k]   <= (CW+SPL)'(r2_absd[k]) * (CW+SPL)'(r2_absnum[SPL-1:0]);
            r3_ph[k]   <= (CW+NUM_W-SPL)'(r2_absd[k])
                        * (CW+NUM_W-SPL)'(r2_absnum[NUM_W-1:SPL]);
            r3_dneg[k] <= r2_dneg[k];
            r3_o[k]    <= r2_o[k];
        end
    end

    // S4: join partial products
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= r3_v;
        end
        o_pl.ok <= r3_ok;
        o_pl.b  <= r3_absden;
        for (int k = 0; k < 3; k++) begin
            o_pl.a[k]    <= DIVD_W'(r3_pl[k]) + (DIVD_W'(r3_ph[k]) << SPL);
            o_pl.dneg[k] <= r3_dneg[k];
            o_pl.o[k]    <= r3_o[k];
        end
    end

endmodule

### rtl/rth_div.sv
// Pipelined restoring divider, three lanes sharing one divisor
module rth_div (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  rth_pkg::t_pl_out i_pl,
    output logic             o_valid,
    output rth_pkg::t_dv_out o_dv
);
    import rth_pkg::*;

    logic              r_v   [QW+1];
    logic              r_ok  [QW+1];
    logic [DEN_W-1:0]  r_b   [QW+1];
    logic [DIVD_W-1:0] r_rem [QW+1][3];
    logic [QW-1:0]     r_q   [QW+1][3];
    t_coord            r_o   [QW+1][3];
    logic              r_dn  [QW+1][3];
    logic              r_sat [QW+1][3];

    // entry: a quotient too wide for its QW bits saturates
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else begin
            r_v[0] <= i_valid;
        end
        r_ok[0] <= i_pl.ok;
        r_b[0]  <= i_pl.b;
        for (int k = 0; k < 3; k++) begin
            r_sat[0][k] <= i_pl.a[k] >= (DIVD_W'(i_pl.b) << QW);
            r_rem[0][k] <= (i_pl.a[k] >= (DIVD_W'(i_pl.b) << QW)) ? '0 : i_pl.a[k];
            r_q[0][k]   <= '0;
            r_o[0][k]   <= i_pl.o[k];
            r_dn[0][k]  <= i_pl.dneg[k];
        end
    end

    // one quotient bit per stage, most significant first
    for (genvar s = 1; s <= QW; s++) begin : g_stage
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s] <= 1'b0;
            end else begin
                r_v[s] <= r_v[s-1];
            end
            r_ok[s] <= r_ok[s-1];
            r_b[s]  <= r_b[s-1];
            for (int k = 0; k < 3; k++) begin
                if (r_rem[s-1][k] >= (DIVD_W'(r_b[s-1]) << (QW - s))) begin
                    r_rem[s][k] <= r_rem[s-1][k] - (DIVD_W'(r_b[s-1]) << (QW - s));
                    r_q[s][k]   <= r_q[s-1][k] | (QW'(1) << (QW - s));
                end else begin
                    r_rem[s][k] <= r_rem[s-1][k];
                    r_q[s][k]   <= r_q[s-1][k];
                end
                r_o[s][k]   <= r_o[s-1][k];
                r_dn[s][k]  <= r_dn[s-1][k];
                r_sat[s][k] <= r_sat[s-1][k];
            end
        end
    end

    always_comb begin
        o_valid = r_v[QW];
        o_dv.ok = r_ok[QW];
        for (int k = 0; k < 3; k++) begin
            o_dv.q[k]    = r_q[QW][k];
            o_dv.o[k]    = r_o[QW][k];
            o_dv.dneg[k] = r_dn[QW][k];
            o_dv.sat[k]  = r_sat[QW][k];
        end
    end

endmodule

### rtl/rth_edge.sv
// Hit point, saturation and an edge sign test for each triangle edge
module rth_edge (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  rth_pkg::t_dv_out i_dv,
    input  rth_pkg::t_tri    i_tri,
    output logic             o_valid,
    output logic             o_hit,
    output logic             o_plane_hit,
    output rth_pkg::t_coord  o_p [3],
    output rth_pkg::t_nrm    o_n [3]
);
    import rth_pkg::*;

    localparam t_coord C_MAX = {1'b0, {(CW-1){1'b1}}};
    localparam t_coord C_MIN = {1'b1, {(CW-1){1'b0}}};

    logic                     r0_v, r1_v, r2_v, r3_v;
    logic                     r0_ok, r1_ok, r2_ok, r3_ok;
    t_coord                   r0_p [3], r1_p [3], r2_p [3], r3_p [3];
    logic signed [QW:0]       n_qs [3];
    logic signed [QW+1:0]     n_sum [3];
    t_coord                   n_p [3];
    logic signed [RW-1:0]     r1_ra [3], r1_rb [3], r1_rc [3];
    logic signed [RW-1:0]     n_eu [3], n_ev [3], n_ew [3];
    logic signed [CRS_W-1:0]  r2_ca [3], r2_cb [3], r2_cc [3];
    logic signed [EDP_W-1:0]  r3_da [3], r3_db [3], r3_dc [3];
    logic signed [EDS_W-1:0]  n_sa, n_sb, n_sc;
    logic                     n_in;

    // E0: signed quotient plus origin, saturated
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_qs[k]  = i_dv.dneg[k] ? -$signed({1'b0, i_dv.q[k]}) : $signed({1'b0, i_dv.q[k]});
            n_sum[k] = (QW+2)'(i_dv.o[k]) + (QW+2)'(n_qs[k]);
            if (i_dv.sat[k]) begin
                n_p[k] = i_dv.dneg[k] ? C_MIN : C_MAX;
            end else if (n_sum[k] > (QW+2)'(C_MAX)) begin
                n_p[k] = C_MAX;
            end else if (n_sum[k] < (QW+2)'(C_MIN)) begin
                n_p[k] = C_MIN;
            end else begin
                n_p[k] = CW'(n_sum[k]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_v <= 1'b0;
        end else begin
            r0_v <= i_valid;
        end
        r0_ok <= i_dv.ok;
        for (int k = 0; k < 3; k++) r0_p[k] <= n_p[k];
    end

    // E1: point relative to each vertex
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else begin
            r1_v <= r0_v;
        end
        r1_ok <= r0_ok;
        for (int k = 0; k < 3; k++) begin
            r1_p[k]  <= r0_p[k];
            r1_ra[k] <= RW'(r0_p[k]) - RW'(i_tri.va[k]);
            r1_rb[k] <= RW'(r0_p[k]) - RW'(i_tri.vb[k]);
            r1_rc[k] <= RW'(r0_p[k]) - RW'(i_tri.vc[k]);
        end
    end

    // edges follow the configuration
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_eu[k] = RW'(i_tri.vb[k]) - RW'(i_tri.va[k]);
            n_ev[k] = RW'(i_tri.vc[k]) - RW'(i_tri.vb[k]);
            n_ew[k] = RW'(i_tri.va[k]) - RW'(i_tri.vc[k]);
        end
    end

    // E2: cross products
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else begin
            r2_v <= r1_v;
        end
        r2_ok <= r1_ok;
        for (int k = 0; k < 3; k++) begin
            r2_p[k]  <= r1_p[k];
            r2_ca[k] <= CRS_W'(n_eu[(k+1)%3] * r1_ra[(k+2)%3])
                      - CRS_W'(n_eu[(k+2)%3] * r1_ra[(k+1)%3]);
            r2_cb[k] <= CRS_W'(n_ev[(k+1)%3] * r1_rb[(k+2)%3])
                      - CRS_W'(n_ev[(k+2)%3] * r1_rb[(k+1)%3]);
            r2_cc[k] <= CRS_W'(n_ew[(k+1)%3] * r1_rc[(k+2)%3])
                      - CRS_W'(n_ew[(k+2)%3] * r1_rc[(k+1)%3]);
        end
    end

    // E3: times the normal
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else begin
            r3_v <= r2_v;
        end
        r3_ok <= r2_ok;
        for (int k = 0; k < 3; k++) begin
            r3_p[k]  <= r2_p[k];
            r3_da[k] <= EDP_W'(r2_ca[k]) * EDP_W'(i_tri.n[k]);
            r3_db[k] <= EDP_W'(r2_cb[k]) * EDP_W'(i_tri.n[k]);
            r3_dc[k] <= EDP_W'(r2_cc[k]) * EDP_W'(i_tri.n[k]);
        end
    end

    // E4: sums, strict common sign
    always_comb begin
        n_sa = EDS_W'(r3_da[0]) + EDS_W'(r3_da[1]) + EDS_W'(r3_da[2]);
        n_sb = EDS_W'(r3_db[0]) + EDS_W'(r3_db[1]) + EDS_W'(r3_db[2]);
        n_sc = EDS_W'(r3_dc[0]) + EDS_W'(r3_dc[1]) + EDS_W'(r3_dc[2]);
        n_in = (n_sa > 0 && n_sb > 0 && n_sc > 0) || (n_sa < 0 && n_sb < 0 && n_sc < 0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= r3_v;
        end
        o_hit       <= r3_ok && n_in;
        o_plane_hit <= r3_ok;
        for (int k = 0; k < 3; k++) begin
            o_p[k] <= r3_ok ? r3_p[k] : '0;
            o_n[k] <= r3_ok ? i_tri.n[k] : '0;
        end
    end

endmodule

### rtl/ray_triangle_hit_test.sv
// Top level of the ray/triangle hit test: register port and pipeline
// One ray enters per clock while busy is low (busy never rises). Each ray's
// result is marked by o_valid for one cycle, and the receiver cannot stall
// it. The pipeline is the 18-stage pipelined divider for the ray parameter (an
// entry stage, then one stage per quotient bit), plus four plane stages and
// five hit-point and edge-test stages. Triangle registers may only be written
// while no ray is in flight; a write takes effect at once on all stages.
module ray_triangle_hit_test (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  rth_pkg::t_coord            i_origin_x,
    input  rth_pkg::t_coord            i_origin_y,
    input  rth_pkg::t_coord            i_origin_z,
    input  rth_pkg::t_coord            i_dir_x,
    input  rth_pkg::t_coord            i_dir_y,
    input  rth_pkg::t_coord            i_dir_z,
    input  logic                       i_allow_backface,
    output logic                       o_valid,
    output logic                       o_hit,
    output logic                       o_plane_hit,
    output rth_pkg::t_coord            o_hit_x,
    output rth_pkg::t_coord            o_hit_y,
    output rth_pkg::t_coord            o_hit_z,
    output rth_pkg::t_nrm              o_normal_x,
    output rth_pkg::t_nrm              o_normal_y,
    output rth_pkg::t_nrm              o_normal_z,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [rth_pkg::ADDR_W-1:0] paddr,
    input  logic [rth_pkg::DATA_W-1:0] pwdata,
    output logic [rth_pkg::DATA_W-1:0] prdata,
    output logic                       pready
);
    import rth_pkg::*;
`include "ray_triangle_hit_test_assert.svh"

    logic [REG_W-1:0] r_va, r_vb, r_vc, r_nrm;
    t_reg_idx         n_idx;
    t_tri             n_tri;
    t_coord           n_o [3], n_d [3];
    logic             n_acc;
    logic             pl_v, dv_v;
    t_pl_out          pl_out;
    t_dv_out          dv_out;
    t_coord           e_p [3];
    t_nrm             e_n [3];

    assign busy   = 1'b0;
    assign pready = 1'b1;
    assign n_acc  = start && !busy;
    assign n_idx  = t_reg_idx'(paddr[ADDR_W-1:3]);

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va  <= '0;
            r_vb  <= '0;
            r_vc  <= '0;
            r_nrm <= '0;
        end else if (psel && penable && pwrite) begin
            unique case (n_idx)
                REG_VA:  r_va  <= pwdata[REG_W-1:0];
                REG_VB:  r_vb  <= pwdata[REG_W-1:0];
                REG_VC:  r_vc  <= pwdata[REG_W-1:0];
                REG_NRM: r_nrm <= pwdata[REG_W-1:0];
                default: ;
            endcase
        end
    end

    // register reads
    always_comb begin
        unique case (n_idx)
            REG_VA:  prdata = DATA_W'(r_va);
            REG_VB:  prdata = DATA_W'(r_vb);
            REG_VC:  prdata = DATA_W'(r_vc);
            REG_NRM: prdata = DATA_W'(r_nrm);
            default: prdata = '0;
        endcase
    end

    // unpack triangle and ray
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_tri.va[k] = get_coord(r_va, k);
            n_tri.vb[k] = get_coord(r_vb, k);
            n_tri.vc[k] = get_coord(r_vc, k);
            n_tri.n[k]  = r_nrm[k*NW +: NW];
        end
        n_o[0] = i_origin_x;
        n_o[1] = i_origin_y;
        n_o[2] = i_origin_z;
        n_d[0] = i_dir_x;
        n_d[1] = i_dir_y;
        n_d[2] = i_dir_z;
    end

    rth_plane u_plane (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (n_acc),
        .i_o     (n_o),
        .i_d     (n_d),
        .i_back  (i_allow_backface),
        .i_tri   (n_tri),
        .o_valid (pl_v),
        .o_pl    (pl_out)
    );

    rth_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (pl_v),
        .i_pl    (pl_out),
        .o_valid (dv_v),
        .o_dv    (dv_out)
    );

    rth_edge u_edge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (dv_v),
        .i_dv        (dv_out),
        .i_tri       (n_tri),
        .o_valid     (o_valid),
        .o_hit       (o_hit),
        .o_plane_hit (o_plane_hit),
        .o_p         (e_p),
        .o_n         (e_n)
    );

    assign o_hit_x    = e_p[0];
    assign o_hit_y    = e_p[1];
    assign o_hit_z    = e_p[2];
    assign o_normal_x = e_n[0];
    assign o_normal_y = e_n[1];
    assign o_normal_z = e_n[2];

    // checks
    `RTH_CHECK(a_hit_needs_plane, o_valid && o_hit, o_plane_hit, "hit without plane hit")
    `RTH_CHECK(a_miss_zero, o_valid && !o_plane_hit,
        o_hit_x == 0 && o_hit_y == 0 && o_hit_z == 0 && o_normal_x == 0 &&
        o_normal_y == 0 && o_normal_z == 0, "rejected ray with non-zero fields")
    `RTH_CHECK_DLY(a_item_latency, n_acc, LAT, o_valid, "item lost in pipeline")

endmodule

### verif/tb_ray_triangle_hit_test.sv
// Self-checking testbench for the ray/triangle hit test: directed table, then random rays
module tb_ray_triangle_hit_test;
    timeunit 1ns;
    timeprecision 1ps;
    import rth_pkg::*;

    localparam int WATCHDOG_CYCLES = 5000;
    localparam int DRAIN_CYCLES    = 40;
    localparam longint EPS         = 419;   // 2^22 / 10000, truncated

    // one result item as the block presents it
    typedef struct {
        logic   hit;
        logic   plane_hit;
        t_coord p [3];
        t_nrm   n [3];
    } t_ray_res;

    // one row of the directed table; rej marks rows expected to be rejected
    typedef struct {
        t_coord o [3];
        t_coord d [3];
        logic   back;
        logic   rej;
    } t_ray_row;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                start = 1'b0;
    logic                busy;
    t_coord              org [3];
    t_coord              dir [3];
    logic                allow_back = 1'b0;
    logic                res_valid, res_hit, res_plane;
    t_coord              res_x, res_y, res_z;
    t_nrm                res_nx, res_ny, res_nz;
    logic                psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [ADDR_W-1:0]   paddr = '0;
    logic [DATA_W-1:0]   pwdata = '0;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    logic [REG_W-1:0]    tri_reg [4];
    t_ray_res            hit_q [$];
    t_ray_res            pend_res [$];
    int                  mismatches = 0;
    int                  idle_cycles = 0;
    logic                timed_out = 1'b0;

    initial begin
        for (int i = 0; i < 3; i++) begin
            org[i] = '0;
            dir[i] = '0;
        end
        for (int i = 0; i < 4; i++) tri_reg[i] = '0;
    end

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    ray_triangle_hit_test dut (
        .i_clk(clk), .i_rst_n(rst_n), .start(start), .busy(busy),
        .i_origin_x(org[0]), .i_origin_y(org[1]), .i_origin_z(org[2]),
        .i_dir_x(dir[0]), .i_dir_y(dir[1]), .i_dir_z(dir[2]),
        .i_allow_backface(allow_back),
        .o_valid(res_valid), .o_hit(res_hit), .o_plane_hit(res_plane),
        .o_hit_x(res_x), .o_hit_y(res_y), .o_hit_z(res_z),
        .o_normal_x(res_nx), .o_normal_y(res_ny), .o_normal_z(res_nz),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    function automatic longint comp_of(input logic [REG_W-1:0] r, input int i);
        t_coord c;
        c = r[i*16 +: 16];
        return longint'(c);
    endfunction

    function automatic longint sat16(input longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    // dot(cross(e, r), n)
    function automatic longint edge_side(input longint e [3], input longint r [3],
                                         input longint n [3]);
        longint c0, c1, c2;
        c0 = e[1] * r[2] - e[2] * r[1];
        c1 = e[2] * r[0] - e[0] * r[2];
        c2 = e[0] * r[1] - e[1] * r[0];
        return c0 * n[0] + c1 * n[1] + c2 * n[2];
    endfunction

    // expected result of one ray against the current triangle
    function automatic t_ray_res trace_ray(input t_coord o_in [3], input t_coord d_in [3],
                                           input logic back);
        t_ray_res r;
        longint o [3], d [3], n [3], a [3], b [3], c [3], p [3];
        longint eu [3], ev [3], ew [3], ra [3], rb [3], rc [3];
        longint den, num, sa, sb, sc;
        r.hit = 1'b0;
        r.plane_hit = 1'b0;
        for (int i = 0; i < 3; i++) begin
            r.p[i] = '0;
            r.n[i] = '0;
            o[i] = longint'(o_in[i]);
            d[i] = longint'(d_in[i]);
            a[i] = comp_of(tri_reg[REG_VA], i);
            b[i] = comp_of(tri_reg[REG_VB], i);
            c[i] = comp_of(tri_reg[REG_VC], i);
            n[i] = comp_of(tri_reg[REG_NRM], i);
        end
        den = d[0] * n[0] + d[1] * n[1] + d[2] * n[2];
        if (!back && den >= 0) return r;
        if (back && (den < 0 ? -den : den) <= EPS) return r;
        num = (n[0] * a[0] + n[1] * a[1] + n[2] * a[2]) - (o[0] * n[0] + o[1] * n[1] + o[2] * n[2]);
        if (num == 0 || ((num < 0) != (den < 0))) return r;
        for (int i = 0; i < 3; i++) p[i] = sat16(o[i] + (d[i] * num) / den);
        for (int i = 0; i < 3; i++) begin
            eu[i] = b[i] - a[i];
            ev[i] = c[i] - b[i];
            ew[i] = a[i] - c[i];
            ra[i] = p[i] - a[i];
            rb[i] = p[i] - b[i];
            rc[i] = p[i] - c[i];
        end
        sa = edge_side(eu, ra, n);
        sb = edge_side(ev, rb, n);
        sc = edge_side(ew, rc, n);
        r.hit = (sa > 0 && sb > 0 && sc > 0) || (sa < 0 && sb < 0 && sc < 0);
        r.plane_hit = 1'b1;
        for (int i = 0; i < 3; i++) begin
            r.p[i] = t_coord'(p[i]);
            r.n[i] = t_nrm'(n[i]);
        end
        return r;
    endfunction

    // acceptance, result checking and watchdog, all on the rising edge
    always @(posedge clk) begin
        t_ray_res want;
        t_ray_res got;
        logic     taken;
        taken = start && !busy && rst_n;
        if (res_valid && rst_n) begin
            got.hit = res_hit;
            got.plane_hit = res_plane;
            got.p[0] = res_x; got.p[1] = res_y; got.p[2] = res_z;
            got.n[0] = res_nx; got.n[1] = res_ny; got.n[2] = res_nz;
            if (hit_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result item at %0t", $realtime);
            end else begin
                want = hit_q.pop_front();
                if (want.hit !== got.hit || want.plane_hit !== got.plane_hit ||
                    want.p[0] !== got.p[0] || want.p[1] !== got.p[1] ||
                    want.p[2] !== got.p[2] || want.n[0] !== got.n[0] ||
                    want.n[1] !== got.n[1] || want.n[2] !== got.n[2]) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch at %0t: exp hit=%0b plane=%0b p=(%0d,%0d,%0d) n=(%0d,%0d,%0d) got hit=%0b plane=%0b p=(%0d,%0d,%0d) n=(%0d,%0d,%0d)",
                            $realtime, want.hit, want.plane_hit, want.p[0], want.p[1],
                            want.p[2], want.n[0], want.n[1], want.n[2], got.hit,
                            got.plane_hit, got.p[0], got.p[1], got.p[2], got.n[0],
                            got.n[1], got.n[2]);
                end
            end
        end
        if (taken) hit_q.push_back(pend_res.pop_front());
        if (taken || res_valid) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= WATCHDOG_CYCLES && !timed_out) begin
            timed_out = 1'b1;
            $display("tb_ray_triangle_hit_test failed");
            $finish;
        end
    end

    // register write over the APB port, setup then access
    task automatic write_reg(input t_reg_idx idx, input logic [REG_W-1:0] val);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= ADDR_W'(int'(idx) * 8);
        pwdata <= DATA_W'(val);
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        tri_reg[idx] = val;
    endtask

    task automatic load_triangle(input logic [REG_W-1:0] a, input logic [REG_W-1:0] b,
                                 input logic [REG_W-1:0] c, input logic [REG_W-1:0] n);
        write_reg(REG_VA, a);
        write_reg(REG_VB, b);
        write_reg(REG_VC, c);
        write_reg(REG_NRM, n);
    endtask

    // present one ray and hold it until the block takes it
    task automatic send_ray(input t_coord o [3], input t_coord d [3], input logic back,
                            input t_ray_res want);
        for (int i = 0; i < 3; i++) begin
            org[i] <= o[i];
            dir[i] <= d[i];
        end
        allow_back <= back;
        start <= 1'b1;
        pend_res.push_back(want);
        do @(posedge clk); while (busy);
        @(negedge clk);
    endtask

    task automatic trace_and_send(input t_coord o [3], input t_coord d [3], input logic back);
        send_ray(o, d, back, trace_ray(o, d, back));
    endtask

    // pause the sender until every expected result item has come
    task automatic drain();
        start <= 1'b0;
        while (hit_q.size() != 0 || pend_res.size() != 0) @(negedge clk);
    endtask

    function automatic logic [REG_W-1:0] pack3(input longint x, input longint y,
                                               input longint z);
        return {16'(z), 16'(y), 16'(x)};
    endfunction

    // random triangle near the origin with its normal worked out in real arithmetic
    task automatic random_triangle(output longint cen [3]);
        longint v [3][3];
        real e1 [3], e2 [3], cr [3], len;
        longint nn [3];
        for (int k = 0; k < 3; k++)
            for (int i = 0; i < 3; i++) v[k][i] = $urandom_range(8192) - 4096;
        for (int i = 0; i < 3; i++) begin
            e1[i] = real'(v[1][i] - v[0][i]);
            e2[i] = real'(v[2][i] - v[0][i]);
            cen[i] = (v[0][i] + v[1][i] + v[2][i]) / 3;
        end
        cr[0] = e1[1] * e2[2] - e1[2] * e2[1];
        cr[1] = e1[2] * e2[0] - e1[0] * e2[2];
        cr[2] = e1[0] * e2[1] - e1[1] * e2[0];
        len = $sqrt(cr[0] * cr[0] + cr[1] * cr[1] + cr[2] * cr[2]);
        for (int i = 0; i < 3; i++)
            nn[i] = (len > 0.0) ? longint'($rtoi(cr[i] / len * 16384.0)) : (i == 2 ? 16384 : 0);
        load_triangle(pack3(v[0][0], v[0][1], v[0][2]), pack3(v[1][0], v[1][1], v[1][2]),
                      pack3(v[2][0], v[2][1], v[2][2]), pack3(nn[0], nn[1], nn[2]));
    endtask

    // random rays: mostly aimed at the triangle, the rest raw noise
    task automatic random_rays(input int count, input int gap_pct, input longint cen [3]);
        t_coord o [3], d [3];
        longint ov;
        for (int k = 0; k < count; k++) begin
            while ($urandom_range(99) < gap_pct) begin
                start <= 1'b0;
                @(negedge clk);
            end
            if ($urandom_range(99) < 70) begin
                for (int i = 0; i < 3; i++) begin
                    ov = cen[i] + $urandom_range(4096) - 2048;
                    o[i] = t_coord'(ov);
                    d[i] = t_coord'((cen[i] + $urandom_range(512) - 256 - ov) / 2);
                end
            end else begin
                for (int i = 0; i < 3; i++) begin
                    o[i] = t_coord'($urandom);
                    d[i] = t_coord'($urandom);
                end
            end
            trace_and_send(o, d, 1'($urandom));
        end
    endtask

    t_ray_row rows [14];

    initial begin
        t_ray_res zero_res;
        longint   cen [3];
        int       gap_pct;

        zero_res.hit = 1'b0;
        zero_res.plane_hit = 1'b0;
        for (int i = 0; i < 3; i++) begin
            zero_res.p[i] = '0;
            zero_res.n[i] = '0;
        end

        // directed table: first two rows run against the reset triangle
        rows[0]  = '{'{16'sh0100, 16'sh0100, 16'sh0400}, '{16'sh0, 16'sh0, -16'sh0100}, 1'b0, 1'b1};
        rows[1]  = '{'{16'sh0100, 16'sh0100, 16'sh0400}, '{16'sh0, 16'sh0, -16'sh0100}, 1'b1, 1'b1};
        // front hit
        rows[2]  = '{'{16'sh0100, 16'sh0100, 16'sh0400}, '{16'sh0, 16'sh0, -16'sh0100}, 1'b0, 1'b0};
        // from behind, backface off then on
        rows[3]  = '{'{16'sh0100, 16'sh0100, -16'sh0400}, '{16'sh0, 16'sh0, 16'sh0100}, 1'b0, 1'b1};
        rows[4]  = '{'{16'sh0100, 16'sh0100, -16'sh0400}, '{16'sh0, 16'sh0, 16'sh0100}, 1'b1, 1'b0};
        // parallel with backface on
        rows[5]  = '{'{16'sh0100, 16'sh0100, 16'sh0400}, '{16'sh0100, 16'sh0, 16'sh0}, 1'b1, 1'b1};
        // plane behind the origin, and origin on the plane
        rows[6]  = '{'{16'sh0100, 16'sh0100, -16'sh0400}, '{16'sh0, 16'sh0, -16'sh0100}, 1'b0, 1'b1};
        rows[7]  = '{'{16'sh0100, 16'sh0100, 16'sh0}, '{16'sh0, 16'sh0, -16'sh0100}, 1'b0, 1'b1};
        // plane hit outside the triangle
        rows[8]  = '{'{16'sh0800, 16'sh0800, 16'sh0400}, '{16'sh0, 16'sh0, -16'sh0100}, 1'b0, 1'b0};
        // far point that saturates
        rows[9]  = '{'{16'sh7fff, 16'sh7fff, 16'sh0001}, '{16'sh7fff, 16'sh7fff, -16'sh0001}, 1'b0, 1'b0};
        // most negative everywhere: plane behind the origin
        rows[10] = '{'{-16'sh8000, -16'sh8000, -16'sh8000}, '{-16'sh8000, -16'sh8000, -16'sh8000}, 1'b0, 1'b1};
        // most positive everywhere, backface on
        rows[11] = '{'{16'sh7fff, 16'sh7fff, 16'sh7fff}, '{16'sh7fff, 16'sh7fff, 16'sh7fff}, 1'b1, 1'b0};
        // point exactly on an edge counts as a miss
        rows[12] = '{'{16'sh0200, 16'sh0, 16'sh0400}, '{16'sh0, 16'sh0, -16'sh0100}, 1'b0, 1'b0};
        // slanted ray inside, backface on
        rows[13] = '{'{16'sh0, 16'sh0, 16'sh0400}, '{16'sh0040, 16'sh0040, -16'sh0100}, 1'b1, 1'b0};

        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int k = 0; k < 14; k++) begin
            if (k == 2) begin
                drain();
                load_triangle(pack3(0, 0, 0), pack3(16'h0400, 0, 0), pack3(0, 16'h0400, 0),
                              pack3(0, 0, 16384));
            end
            if (rows[k].rej) send_ray(rows[k].o, rows[k].d, rows[k].back, zero_res);
            else trace_and_send(rows[k].o, rows[k].d, rows[k].back);
        end

        // random phases, each on its own triangle, between idle settings
        for (int ph = 0; ph < 9; ph++) begin
            drain();
            case (ph)
                3: begin
                    // all ones: every coordinate -1
                    load_triangle({REG_W{1'b1}}, {REG_W{1'b1}}, {REG_W{1'b1}}, {REG_W{1'b1}});
                    for (int i = 0; i < 3; i++) cen[i] = 0;
                end
                5: begin
                    // extreme vertices with a normal outside the unit range
                    load_triangle(pack3(32767, -32768, 0), pack3(-32768, 32767, 32767),
                                  pack3(0, 0, -32768), pack3(32767, -32768, 32767));
                    for (int i = 0; i < 3; i++) cen[i] = 0;
                end
                7: begin
                    // degenerate: all vertices coincide
                    load_triangle(pack3(256, 256, 256), pack3(256, 256, 256),
                                  pack3(256, 256, 256), pack3(0, 0, 16384));
                    for (int i = 0; i < 3; i++) cen[i] = 256;
                end
                default: random_triangle(cen);
            endcase
            gap_pct = (ph % 3 == 0) ? 32 : ((ph % 3 == 1) ? 60 : 0);
            random_rays(190, gap_pct, cen);
        end

        drain();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mismatches == 0 && hit_q.size() == 0) begin
            $display("tb_ray_triangle_hit_test passed");
        end else begin
            $display("tb_ray_triangle_hit_test failed");
        end
        $finish;
    end

endmodule

### files.f
+incdir+rtl
rtl/rth_pkg.sv
rtl/rth_plane.sv
rtl/rth_div.sv
rtl/rth_edge.sv
rtl/ray_triangle_hit_test.sv
verif/tb_ray_triangle_hit_test.sv
